// ----- hw/rtl/gps_pkg.sv -----
// Package for the gated pedestal subtractor: sizes, register indexes,
// state encoding, divider handshake types and the saturating subtract.
// No dependencies.
package gps_pkg;

	localparam int WINDOW_MAX = 64;
	localparam int FRAC_BITS  = 4;
	localparam int ADDR_W     = $clog2(WINDOW_MAX);
	localparam int IDX_W      = $clog2(WINDOW_MAX + 1);
	localparam int SUM_W      = 23;
	localparam int CNT_W      = 7;
	localparam int DIV_STEPS  = SUM_W;
	localparam int STEP_W     = $clog2(DIV_STEPS);
	localparam int THR_W      = 15;
	localparam int WLEN_W     = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = CFG_IDX_W'(1);

	localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(100 << FRAC_BITS);
	localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(50);

	typedef enum logic [1:0] {
		ST_FILL,
		ST_DIV,
		ST_FLUSH,
		ST_PASS
	} gps_state_t;

	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [SUM_W-1:0] quotient;
	} div_rsp_t;

	function automatic logic signed [15:0] sat_sub(logic signed [15:0] a,
			logic signed [15:0] b);
		logic signed [16:0] d;
		d = $signed({a[15], a}) - $signed({b[15], b});
		if (d[16] != d[15]) begin
			return d[16] ? 16'sh8000 : 16'sh7FFF;
		end
		return d[15:0];
	endfunction

endpackage

// ----- hw/rtl/gps_if.sv -----
// Channel interfaces of the gated pedestal subtractor: sample input,
// result output and configuration write. Uses gps_pkg.
interface gps_sample_if import gps_pkg::*; ();
	logic               valid;
	logic               ready;
	logic signed [15:0] sample_value;
	logic [15:0]        sample_clock;
	logic               pulse_end;

	modport source (output valid, sample_value, sample_clock, pulse_end, input ready);
	modport sink (input valid, sample_value, sample_clock, pulse_end, output ready);
endinterface

interface gps_result_if import gps_pkg::*; ();
	logic               valid;
	logic               ready;
	logic signed [15:0] corrected_value;
	logic [15:0]        out_clock;
	logic               out_last;
	logic               no_valid_flag;

	modport source (output valid, corrected_value, out_clock, out_last, no_valid_flag,
		input ready);
	modport sink (input valid, corrected_value, out_clock, out_last, no_valid_flag,
		output ready);
endinterface

interface gps_cfg_if import gps_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  reg_index;
	logic [CFG_DATA_W-1:0] wdata;

	modport source (output valid, reg_index, wdata, input ready);
	modport sink (input valid, reg_index, wdata, output ready);
endinterface

// ----- hw/rtl/gated_pedestal_subtractor_unit.sv -----
// Gated pedestal subtractor, top level. Uses gps_pkg, gps_if, gps_divider.
// Window fill: one sample per cycle, no result. On window close: pedestal
// division (skipped when no sample passed), then buffered samples leave
// one per registered store read, each read waiting for the last beat to
// go out. After the window: one sample per cycle unless the output stalls.
// Reset clears control state, loads register defaults; sample store kept.
module gated_pedestal_subtractor_unit import gps_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	gps_cfg_if.sink     cfg,
	gps_sample_if.sink  sample,
	gps_result_if.source result
);

	gps_state_t state_q, state_nx;

	logic [THR_W-1:0]        thr_q;
	logic [WLEN_W-1:0]       wlen_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [IDX_W-1:0]        idx_q;
	logic signed [15:0]      ped_q;
	logic                    last_q;
	logic [IDX_W-1:0]        flush_q;
	logic                    rd_pend_q;

	logic               ovalid_q;
	logic signed [15:0] oval_q;
	logic [15:0]        oclk_q;
	logic               olast_q;
	logic               onv_q;

	logic [31:0] store_mem [WINDOW_MAX];
	logic [31:0] rdata_q;

	logic signed [16:0]      sv17;
	logic [16:0]             mag;
	logic                    pass;
	logic signed [SUM_W-1:0] sum_nx;
	logic [CNT_W-1:0]        cnt_nx;
	logic [IDX_W-1:0]        idx_nx;
	logic [IDX_W-1:0]        wl_eff;
	logic                    close;
	logic                    out_free;
	logic                    acc;
	logic                    in_ready;
	logic                    mem_we;
	logic                    rd_issue;
	logic                    flush_emit;
	logic                    flush_done;
	logic                    pass_emit;
	logic                    last_beat;
	logic signed [15:0]      quo16;
	div_req_t                dreq;
	div_rsp_t                drsp;

	gps_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	assign sv17   = $signed({sample.sample_value[15], sample.sample_value});
	assign mag    = sv17[16] ? 17'(-sv17) : 17'(sv17);
	assign pass   = mag < {2'b00, thr_q};
	assign sum_nx = pass ? sum_q + SUM_W'(sample.sample_value) : sum_q;
	assign cnt_nx = cnt_q + CNT_W'(pass);
	assign idx_nx = idx_q + 1'b1;
	assign wl_eff = (wlen_q == '0) ? IDX_W'(1) :
		(wlen_q > WLEN_W'(WINDOW_MAX)) ? IDX_W'(WINDOW_MAX) : IDX_W'(wlen_q);
	assign close     = (idx_nx >= wl_eff) || sample.pulse_end;
	assign out_free  = !ovalid_q || result.ready;
	assign acc       = sample.valid && in_ready;
	assign last_beat = (flush_q + 1'b1) == idx_q;
	assign quo16     = $signed(drsp.quotient[15:0]);

	assign dreq.start    = acc && (state_q == ST_FILL) && close && (cnt_nx != '0);
	assign dreq.dividend = sum_nx[SUM_W-1] ? SUM_W'(-sum_nx) : SUM_W'(sum_nx);
	assign dreq.divisor  = cnt_nx;

	always_comb begin
		in_ready   = 1'b0;
		mem_we     = 1'b0;
		rd_issue   = 1'b0;
		flush_emit = 1'b0;
		pass_emit  = 1'b0;
		case (state_q)
			ST_FILL: begin
				in_ready = 1'b1;
				mem_we   = sample.valid;
			end
			ST_FLUSH: begin
				rd_issue   = !rd_pend_q && (flush_q != idx_q);
				flush_emit = rd_pend_q && out_free;
			end
			ST_PASS: begin
				in_ready  = out_free;
				pass_emit = sample.valid && out_free;
			end
			default: begin
			end
		endcase
	end

	assign flush_done = flush_emit && last_beat;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_FILL: begin
				if (acc && close) begin
					state_nx = (cnt_nx == '0) ? ST_FLUSH : ST_DIV;
				end
			end
			ST_DIV: begin
				if (drsp.done) begin
					state_nx = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (flush_done) begin
					state_nx = last_q ? ST_FILL : ST_PASS;
				end
			end
			ST_PASS: begin
				if (acc && sample.pulse_end) begin
					state_nx = ST_FILL;
				end
			end
			default: begin
				state_nx = ST_FILL;
			end
		endcase
	end

	assign cfg.ready    = 1'b1;
	assign sample.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_FILL;
			thr_q     <= THR_RESET;
			wlen_q    <= WLEN_RESET;
			sum_q     <= '0;
			cnt_q     <= '0;
			idx_q     <= '0;
			ped_q     <= '0;
			last_q    <= 1'b0;
			flush_q   <= '0;
			rd_pend_q <= 1'b0;
			ovalid_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg.valid) begin
				case (cfg.reg_index)
					REG_THRESHOLD: thr_q  <= cfg.wdata[THR_W-1:0];
					REG_WINDOW:    wlen_q <= cfg.wdata[WLEN_W-1:0];
					default: begin
					end
				endcase
			end
			if (acc && state_q == ST_FILL) begin
				sum_q <= sum_nx;
				cnt_q <= cnt_nx;
				idx_q <= idx_nx;
				if (close) begin
					last_q  <= sample.pulse_end;
					flush_q <= '0;
				end
			end
			if (state_q == ST_DIV && drsp.done) begin
				ped_q <= sum_q[SUM_W-1] ? -quo16 : quo16;
			end
			if (rd_issue) begin
				rd_pend_q <= 1'b1;
			end else if (flush_emit) begin
				rd_pend_q <= 1'b0;
				flush_q   <= flush_q + 1'b1;
			end
			if ((flush_done && last_q) || (pass_emit && sample.pulse_end)) begin
				sum_q <= '0;
				cnt_q <= '0;
				idx_q <= '0;
				ped_q <= '0;
			end
			if (flush_emit || pass_emit) begin
				ovalid_q <= 1'b1;
			end else if (result.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (flush_emit) begin
			oval_q  <= sat_sub($signed(rdata_q[15:0]), ped_q);
			oclk_q  <= rdata_q[31:16];
			olast_q <= last_q && last_beat;
			onv_q   <= cnt_q == '0;
		end else if (pass_emit) begin
			oval_q  <= sat_sub(sample.sample_value, ped_q);
			oclk_q  <= sample.sample_clock;
			olast_q <= sample.pulse_end;
			onv_q   <= cnt_q == '0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[idx_q[ADDR_W-1:0]] <= {sample.sample_clock, sample.sample_value};
		end
		if (rd_issue) begin
			rdata_q <= store_mem[flush_q[ADDR_W-1:0]];
		end
	end

	assign result.valid           = ovalid_q;
	assign result.corrected_value = oval_q;
	assign result.out_clock       = oclk_q;
	assign result.out_last        = olast_q;
	assign result.no_valid_flag   = onv_q;

endmodule

// ----- hw/rtl/gps_divider.sv -----
// Restoring divider for the pedestal: unsigned dividend by a small count,
// one quotient bit per cycle. Uses gps_pkg.
module gps_divider import gps_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic             busy_q;
	logic             done_q;
	logic [STEP_W-1:0] step_q;
	logic [SUM_W-1:0] dvd_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] dsr_q;
	logic [CNT_W:0]   rem_sh;
	logic             fits;

	assign rem_sh = {rem_q, dvd_q[SUM_W-1]};
	assign fits   = rem_sh >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? CNT_W'(rem_sh - {1'b0, dsr_q}) : rem_sh[CNT_W-1:0];
			dvd_q <= {dvd_q[SUM_W-2:0], fits};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule
